>>> rtl/core/lav_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants of the look-at view matrix pipeline
// no dependencies

package lav_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned UnitW     = 18;
  localparam int unsigned ProdW     = CoordW + UnitW;
  localparam int unsigned CrossW    = ProdW + 1;
  localparam int unsigned FrW       = 2 * UnitW;
  localparam int unsigned CuW       = FrW + 1;
  localparam int unsigned UpW       = 20;
  localparam int unsigned UeW       = CoordW + UpW;
  localparam int unsigned DotW      = 56;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned RndW      = DotW - FracBits;
  localparam int unsigned NrmW      = 31;
  localparam int unsigned NormBit   = 30;
  localparam int unsigned SumW      = 64;
  localparam int unsigned RootSteps = 32;
  localparam int unsigned LenW      = 32;
  localparam int unsigned QuoW      = 17;

  localparam logic [UnitW-1:0]  OneQ16  = UnitW'(65536);
  localparam logic [UnitW-1:0]  SteepY  = UnitW'(64880);
  localparam logic [CoordW-1:0] SatMax  = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] SatMin  = 32'h8000_0000;
  localparam int unsigned       HalfLsb = 32768;

  typedef logic [2:0][CoordW-1:0] coord3_t;
  typedef logic [2:0][UnitW-1:0]  unit3_t;

  typedef struct packed {
    logic signed [CoordW-1:0] eye_x;
    logic signed [CoordW-1:0] eye_y;
    logic signed [CoordW-1:0] eye_z;
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
    logic signed [CoordW-1:0] target_z;
    logic signed [CoordW-1:0] up_hint_x;
    logic signed [CoordW-1:0] up_hint_y;
    logic signed [CoordW-1:0] up_hint_z;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] right_x;
    logic signed [CoordW-1:0] right_y;
    logic signed [CoordW-1:0] right_z;
    logic signed [CoordW-1:0] right_shift;
    logic signed [CoordW-1:0] true_up_x;
    logic signed [CoordW-1:0] true_up_y;
    logic signed [CoordW-1:0] true_up_z;
    logic signed [CoordW-1:0] true_up_shift;
    logic signed [CoordW-1:0] back_x;
    logic signed [CoordW-1:0] back_y;
    logic signed [CoordW-1:0] back_z;
    logic signed [CoordW-1:0] back_shift;
  } out_t;

  // rounded magnitude and sign to saturated 32 bit value
  function automatic logic [CoordW-1:0] sat_shift(input logic pos, input logic [RndW-1:0] mag);
    logic [RndW-1:0] lim;
    logic [RndW-1:0] neg_mag;
    lim     = pos ? RndW'(SatMax) : RndW'(SatMin);
    neg_mag = -mag;
    if (mag > lim) begin
      return pos ? SatMax : SatMin;
    end
    return pos ? mag[CoordW-1:0] : neg_mag[CoordW-1:0];
  endfunction

endpackage

>>> rtl/core/lav_unit.sv
`timescale 1ns / 1ps
// pipelined unit vector: normalise, square, bit-per-stage root, restoring divide
// depends on lav_pkg

module lav_unit #(
  parameter int unsigned InW   = lav_pkg::DiffW,
  parameter int unsigned SideW = lav_pkg::DiffW
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [2:0][InW-1:0]                vec_i,
  input  logic [SideW-1:0]                   side_i,
  output logic                               valid_o,
  output logic                               nz_o,
  output logic [2:0][lav_pkg::UnitW-1:0]     vec_o,
  output logic [SideW-1:0]                   side_o
);

  localparam int unsigned NrmW  = lav_pkg::NrmW;
  localparam int unsigned PosW  = $clog2(InW);
  localparam int unsigned SqW   = 2 * NrmW;
  localparam int unsigned SumW  = lav_pkg::SumW;
  localparam int unsigned Steps = lav_pkg::RootSteps;
  localparam int unsigned LenW  = lav_pkg::LenW;
  localparam int unsigned QuoW  = lav_pkg::QuoW;
  localparam int unsigned Frac  = lav_pkg::FracBits;
  localparam int unsigned DvW   = NrmW + Frac + 1;
  localparam int unsigned UnitW = lav_pkg::UnitW;
  localparam int unsigned Lat   = Steps + QuoW + 7;
  localparam logic [PosW-1:0] NormPos = PosW'(lav_pkg::NormBit);

  typedef struct packed {
    logic [SideW-1:0]     side;
    logic [2:0]           neg;
    logic                 nz;
    logic [2:0][NrmW-1:0] m;
  } nrm_t;

  typedef struct packed {
    nrm_t            n;
    logic [SumW-1:0] num;
    logic [SumW-1:0] res;
  } root_t;

  typedef struct packed {
    logic [SideW-1:0]     side;
    logic [2:0]           neg;
    logic                 nz;
    logic [LenW-1:0]      len;
    logic [2:0][DvW-1:0]  num;
    logic [2:0][LenW-1:0] rem;
    logic [2:0][QuoW-1:0] quo;
  } div_t;

  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[Lat-1];

  // magnitudes and combined leading one
  logic [2:0]          s1_neg_d;
  logic [2:0][InW-1:0] s1_mag_d;
  logic [SideW-1:0]    s1_side_q;
  logic [2:0]          s1_neg_q;
  logic [2:0][InW-1:0] s1_mag_q;
  logic [InW-1:0]      s1_or_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_neg_d[k] = vec_i[k][InW-1];
      s1_mag_d[k] = s1_neg_d[k] ? (~vec_i[k] + 1'b1) : vec_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_side_q <= side_i;
      s1_neg_q  <= s1_neg_d;
      s1_mag_q  <= s1_mag_d;
      s1_or_q   <= s1_mag_d[0] | s1_mag_d[1] | s1_mag_d[2];
    end
  end

  logic [PosW-1:0]     s2_pos_d;
  logic [PosW-1:0]     s2_pos_q;
  logic                s2_nz_q;
  logic [SideW-1:0]    s2_side_q;
  logic [2:0]          s2_neg_q;
  logic [2:0][InW-1:0] s2_mag_q;

  always_comb begin
    s2_pos_d = '0;
    for (int b = 0; b < InW; b++) begin
      if (s1_or_q[b]) begin
        s2_pos_d = PosW'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_pos_q  <= s2_pos_d;
      s2_nz_q   <= |s1_or_q;
      s2_side_q <= s1_side_q;
      s2_neg_q  <= s1_neg_q;
      s2_mag_q  <= s1_mag_q;
    end
  end

  // common power of two scale
  nrm_t                     s3_d;
  nrm_t                     s3_q;
  logic [2:0][InW+NrmW-1:0] ext;

  always_comb begin
    s3_d.side = s2_side_q;
    s3_d.neg  = s2_neg_q;
    s3_d.nz   = s2_nz_q;
    for (int k = 0; k < 3; k++) begin
      ext[k] = {{NrmW{1'b0}}, s2_mag_q[k]};
      if (s2_pos_q >= NormPos) begin
        ext[k] = ext[k] >> (s2_pos_q - NormPos);
      end else begin
        ext[k] = ext[k] << (NormPos - s2_pos_q);
      end
      s3_d.m[k] = ext[k][NrmW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q <= s3_d;
    end
  end

  nrm_t                s4_q;
  logic [2:0][SqW-1:0] s4_sq_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_q <= s3_q;
      for (int k = 0; k < 3; k++) begin
        s4_sq_q[k] <= SqW'(s3_q.m[k]) * SqW'(s3_q.m[k]);
      end
    end
  end

  root_t rt_q [Steps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_q[0].n   <= s4_q;
      rt_q[0].num <= SumW'(s4_sq_q[0]) + SumW'(s4_sq_q[1]) + SumW'(s4_sq_q[2]);
      rt_q[0].res <= '0;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_root
    localparam logic [SumW-1:0] RootBit = SumW'(1) << (SumW - 2 - 2 * k);
    root_t           rt_d;
    logic [SumW-1:0] trial;

    always_comb begin
      rt_d  = rt_q[k];
      trial = rt_q[k].res + RootBit;
      if (rt_q[k].num >= trial) begin
        rt_d.num = rt_q[k].num - trial;
        rt_d.res = (rt_q[k].res >> 1) + RootBit;
      end else begin
        rt_d.res = rt_q[k].res >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_q[k+1] <= rt_d;
      end
    end
  end

  div_t dv_q [QuoW+1];
  div_t dv0_d;

  always_comb begin
    dv0_d.side = rt_q[Steps].n.side;
    dv0_d.neg  = rt_q[Steps].n.neg;
    dv0_d.nz   = rt_q[Steps].n.nz;
    dv0_d.len  = rt_q[Steps].res[LenW-1:0];
    for (int k = 0; k < 3; k++) begin
      dv0_d.num[k] = DvW'({rt_q[Steps].n.m[k], {Frac{1'b0}}}) + DvW'(dv0_d.len >> 1);
      dv0_d.rem[k] = LenW'(dv0_d.num[k] >> QuoW);
      dv0_d.quo[k] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q[0] <= dv0_d;
    end
  end

  for (genvar j = 0; j < QuoW; j++) begin : g_div
    div_t               dv_d;
    logic [2:0][LenW:0] trial;

    always_comb begin
      dv_d = dv_q[j];
      for (int k = 0; k < 3; k++) begin
        trial[k] = {dv_q[j].rem[k], dv_q[j].num[k][QuoW-1-j]};
        if (trial[k] >= {1'b0, dv_q[j].len}) begin
          dv_d.rem[k] = LenW'(trial[k] - {1'b0, dv_q[j].len});
          dv_d.quo[k] = {dv_q[j].quo[k][QuoW-2:0], 1'b1};
        end else begin
          dv_d.rem[k] = trial[k][LenW-1:0];
          dv_d.quo[k] = {dv_q[j].quo[k][QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[j+1] <= dv_d;
      end
    end
  end

  logic [2:0][UnitW-1:0] vec_d;
  logic [2:0][UnitW-1:0] vec_q;
  logic                  nz_q;
  logic [SideW-1:0]      side_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vec_d[k] = dv_q[QuoW].neg[k] ? -UnitW'(dv_q[QuoW].quo[k]) : UnitW'(dv_q[QuoW].quo[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q  <= vec_d;
      nz_q   <= dv_q[QuoW].nz;
      side_q <= dv_q[QuoW].side;
    end
  end

  assign vec_o  = vec_q;
  assign nz_o   = nz_q;
  assign side_o = side_q;

endmodule

>>> rtl/core/look_at_view_matrix.sv
`timescale 1ns / 1ps
// look-at view matrix, top three rows, signed q16.16, one transaction per cycle when not stalled
// depends on lav_pkg and lav_unit
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+-------------------------
//  input    | in_valid_i  | in_stall_o  | in_data_i  (lav_pkg::in_t)
//  output   | out_valid_o | out_stall_i | out_data_o (lav_pkg::out_t)
//
// one transaction enters per cycle unless the output is stalled; the path runs through
// 13 top stages plus two unit-vector pipelines of 56 stages, set by the
// 32-stage square root and 17-stage divider in each
// reset clears the valid bits only; the datapath needs no clearing
// a stalled output freezes the whole pipeline, in_stall_o follows it

module look_at_view_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lav_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lav_pkg::out_t  out_data_o
);

  localparam int unsigned CoordW = lav_pkg::CoordW;
  localparam int unsigned DiffW  = lav_pkg::DiffW;
  localparam int unsigned UnitW  = lav_pkg::UnitW;
  localparam int unsigned ProdW  = lav_pkg::ProdW;
  localparam int unsigned CrossW = lav_pkg::CrossW;
  localparam int unsigned FrW    = lav_pkg::FrW;
  localparam int unsigned CuW    = lav_pkg::CuW;
  localparam int unsigned UpW    = lav_pkg::UpW;
  localparam int unsigned UeW    = lav_pkg::UeW;
  localparam int unsigned DotW   = lav_pkg::DotW;
  localparam int unsigned RndW   = lav_pkg::RndW;
  localparam int unsigned Frac   = lav_pkg::FracBits;

  typedef struct packed {
    lav_pkg::coord3_t eye;
    lav_pkg::coord3_t up;
  } side_a_t;

  typedef struct packed {
    lav_pkg::coord3_t eye;
    lav_pkg::unit3_t  f;
  } side_b_t;

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic       va;
  logic       vb;
  logic [1:0] pa_q;
  logic [2:0] pb_q;
  logic [7:0] pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q <= '0;
      pb_q <= '0;
      pc_q <= '0;
    end else if (en) begin
      pa_q <= {pa_q[0], in_valid_i};
      pb_q <= {pb_q[1:0], va};
      pc_q <= {pc_q[6:0], vb};
    end
  end

  assign out_valid_o = pc_q[7];

  // input and difference
  lav_pkg::in_t           in_q;
  lav_pkg::coord3_t       eye0;
  lav_pkg::coord3_t       tgt0;
  lav_pkg::coord3_t       up0;
  logic [2:0][DiffW-1:0]  d1_q;
  lav_pkg::coord3_t       e1_q;
  lav_pkg::coord3_t       up1_q;

  assign eye0 = {in_q.eye_z, in_q.eye_y, in_q.eye_x};
  assign tgt0 = {in_q.target_z, in_q.target_y, in_q.target_x};
  assign up0  = {in_q.up_hint_z, in_q.up_hint_y, in_q.up_hint_x};

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q  <= in_data_i;
      e1_q  <= eye0;
      up1_q <= up0;
      for (int k = 0; k < 3; k++) begin
        d1_q[k] <= DiffW'($signed(eye0[k])) - DiffW'($signed(tgt0[k]));
      end
    end
  end

  logic             nza;
  lav_pkg::unit3_t  fa;
  side_a_t          sa_o;

  lav_unit #(
    .InW   (DiffW),
    .SideW ($bits(side_a_t))
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pa_q[1]),
    .vec_i   (d1_q),
    .side_i  ({e1_q, up1_q}),
    .valid_o (va),
    .nz_o    (nza),
    .vec_o   (fa),
    .side_o  (sa_o)
  );

  // forward fallback, cross(up, f) products
  lav_pkg::unit3_t       f2_d;
  lav_pkg::unit3_t       f2_q;
  lav_pkg::coord3_t      e2_q;
  lav_pkg::coord3_t      up2_q;
  logic [5:0][ProdW-1:0] p3_q;
  lav_pkg::unit3_t       f3_q;
  lav_pkg::coord3_t      e3_q;

  always_comb begin
    if (nza) begin
      f2_d = fa;
    end else begin
      f2_d[0] = '0;
      f2_d[1] = '0;
      f2_d[2] = lav_pkg::OneQ16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_q  <= f2_d;
      e2_q  <= sa_o.eye;
      up2_q <= sa_o.up;
      p3_q[0] <= ProdW'($signed(up2_q[1])) * ProdW'($signed(f2_q[2]));
      p3_q[1] <= ProdW'($signed(up2_q[2])) * ProdW'($signed(f2_q[1]));
      p3_q[2] <= ProdW'($signed(up2_q[2])) * ProdW'($signed(f2_q[0]));
      p3_q[3] <= ProdW'($signed(up2_q[0])) * ProdW'($signed(f2_q[2]));
      p3_q[4] <= ProdW'($signed(up2_q[0])) * ProdW'($signed(f2_q[1]));
      p3_q[5] <= ProdW'($signed(up2_q[1])) * ProdW'($signed(f2_q[0]));
      f3_q  <= f2_q;
      e3_q  <= e2_q;
    end
  end

  // cross product, or the substitute up when it vanishes
  logic [2:0][CrossW-1:0] c4_d;
  logic [2:0][CrossW-1:0] cr;
  logic [2:0][CrossW-1:0] fs;
  logic [UnitW-1:0]       fy_mag;
  logic [2:0][CrossW-1:0] c4_q;
  lav_pkg::unit3_t        f4_q;
  lav_pkg::coord3_t       e4_q;

  always_comb begin
    cr[0]  = CrossW'($signed(p3_q[0])) - CrossW'($signed(p3_q[1]));
    cr[1]  = CrossW'($signed(p3_q[2])) - CrossW'($signed(p3_q[3]));
    cr[2]  = CrossW'($signed(p3_q[4])) - CrossW'($signed(p3_q[5]));
    for (int k = 0; k < 3; k++) begin
      fs[k] = CrossW'($signed(f3_q[k])) <<< Frac;
    end
    fy_mag = f3_q[1][UnitW-1] ? -f3_q[1] : f3_q[1];
    if (cr != '0) begin
      c4_d = cr;
    end else if (fy_mag > lav_pkg::SteepY) begin
      c4_d[0] = -fs[1];
      c4_d[1] = fs[0];
      c4_d[2] = '0;
    end else begin
      c4_d[0] = fs[2];
      c4_d[1] = '0;
      c4_d[2] = -fs[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q <= c4_d;
      f4_q <= f3_q;
      e4_q <= e3_q;
    end
  end

  logic             nzb;
  lav_pkg::unit3_t  rb;
  side_b_t          sb_o;

  lav_unit #(
    .InW   (CrossW),
    .SideW ($bits(side_b_t))
  ) u_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pb_q[2]),
    .vec_i   (c4_q),
    .side_i  ({e4_q, f4_q}),
    .valid_o (vb),
    .nz_o    (nzb),
    .vec_o   (rb),
    .side_o  (sb_o)
  );

  // right fallback, then true up and the translations
  lav_pkg::unit3_t       r5_d;
  lav_pkg::unit3_t       r5_q;
  lav_pkg::unit3_t       f5_q;
  lav_pkg::coord3_t      e5_q;
  logic [5:0][FrW-1:0]   fr6_q;
  logic [2:0][ProdW-1:0] re6_q;
  logic [2:0][ProdW-1:0] fe6_q;
  lav_pkg::unit3_t       r6_q;
  lav_pkg::unit3_t       f6_q;
  lav_pkg::coord3_t      e6_q;

  always_comb begin
    if (nzb) begin
      r5_d = rb;
    end else begin
      r5_d[0] = lav_pkg::OneQ16;
      r5_d[1] = '0;
      r5_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r5_q <= r5_d;
      f5_q <= sb_o.f;
      e5_q <= sb_o.eye;
      fr6_q[0] <= FrW'($signed(f5_q[1])) * FrW'($signed(r5_q[2]));
      fr6_q[1] <= FrW'($signed(f5_q[2])) * FrW'($signed(r5_q[1]));
      fr6_q[2] <= FrW'($signed(f5_q[2])) * FrW'($signed(r5_q[0]));
      fr6_q[3] <= FrW'($signed(f5_q[0])) * FrW'($signed(r5_q[2]));
      fr6_q[4] <= FrW'($signed(f5_q[0])) * FrW'($signed(r5_q[1]));
      fr6_q[5] <= FrW'($signed(f5_q[1])) * FrW'($signed(r5_q[0]));
      for (int k = 0; k < 3; k++) begin
        re6_q[k] <= ProdW'($signed(r5_q[k])) * ProdW'($signed(e5_q[k]));
        fe6_q[k] <= ProdW'($signed(f5_q[k])) * ProdW'($signed(e5_q[k]));
      end
      r6_q <= r5_q;
      f6_q <= f5_q;
      e6_q <= e5_q;
    end
  end

  logic [2:0][CuW-1:0] cu7_q;
  logic [DotW-1:0]     dr7_q;
  logic [DotW-1:0]     df7_q;
  lav_pkg::unit3_t     r7_q;
  lav_pkg::unit3_t     f7_q;
  lav_pkg::coord3_t    e7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cu7_q[0] <= CuW'($signed(fr6_q[0])) - CuW'($signed(fr6_q[1]));
      cu7_q[1] <= CuW'($signed(fr6_q[2])) - CuW'($signed(fr6_q[3]));
      cu7_q[2] <= CuW'($signed(fr6_q[4])) - CuW'($signed(fr6_q[5]));
      dr7_q <= DotW'($signed(re6_q[0])) + DotW'($signed(re6_q[1]))
             + DotW'($signed(re6_q[2]));
      df7_q <= DotW'($signed(fe6_q[0])) + DotW'($signed(fe6_q[1]))
             + DotW'($signed(fe6_q[2]));
      r7_q  <= r6_q;
      f7_q  <= f6_q;
      e7_q  <= e6_q;
    end
  end

  // true up rounded half away from zero
  logic [2:0][CuW-1:0] ut;
  logic [2:0][UpW-1:0] u8_d;
  logic [2:0][UpW-1:0] u8_q;
  logic [DotW-1:0]     dr8_q;
  logic [DotW-1:0]     df8_q;
  lav_pkg::unit3_t     r8_q;
  lav_pkg::unit3_t     f8_q;
  lav_pkg::coord3_t    e8_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ut[k] = cu7_q[k][CuW-1] ? (CuW'(lav_pkg::HalfLsb) - cu7_q[k])
                              : (cu7_q[k] + CuW'(lav_pkg::HalfLsb));
      ut[k] = ut[k] >> Frac;
      u8_d[k] = cu7_q[k][CuW-1] ? -UpW'(ut[k]) : UpW'(ut[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u8_q  <= u8_d;
      dr8_q <= dr7_q;
      df8_q <= df7_q;
      r8_q  <= r7_q;
      f8_q  <= f7_q;
      e8_q  <= e7_q;
    end
  end

  logic [2:0][UeW-1:0] ue9_q;
  logic [2:0][UpW-1:0] u9_q;
  logic [DotW-1:0]     dr9_q;
  logic [DotW-1:0]     df9_q;
  lav_pkg::unit3_t     r9_q;
  lav_pkg::unit3_t     f9_q;
  logic [DotW-1:0]     du10_q;
  logic [2:0][UpW-1:0] u10_q;
  logic [DotW-1:0]     dr10_q;
  logic [DotW-1:0]     df10_q;
  lav_pkg::unit3_t     r10_q;
  lav_pkg::unit3_t     f10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ue9_q[k] <= UeW'($signed(u8_q[k])) * UeW'($signed(e8_q[k]));
      end
      u9_q   <= u8_q;
      dr9_q  <= dr8_q;
      df9_q  <= df8_q;
      r9_q   <= r8_q;
      f9_q   <= f8_q;
      du10_q <= DotW'($signed(ue9_q[0])) + DotW'($signed(ue9_q[1]))
              + DotW'($signed(ue9_q[2]));
      u10_q  <= u9_q;
      dr10_q <= dr9_q;
      df10_q <= df9_q;
      r10_q  <= r9_q;
      f10_q  <= f9_q;
    end
  end

  // negated dot products rounded, then saturated
  logic [2:0][DotW-1:0] dots;
  logic [2:0][DotW-1:0] dt;
  logic [2:0][RndW-1:0] mag11_d;
  logic [2:0][RndW-1:0] mag11_q;
  logic [2:0]           pos11_q;
  logic [2:0][UpW-1:0]  u11_q;
  lav_pkg::unit3_t      r11_q;
  lav_pkg::unit3_t      f11_q;

  always_comb begin
    dots[0] = dr10_q;
    dots[1] = du10_q;
    dots[2] = df10_q;
    for (int k = 0; k < 3; k++) begin
      dt[k] = dots[k][DotW-1] ? (DotW'(lav_pkg::HalfLsb) - dots[k])
                              : (dots[k] + DotW'(lav_pkg::HalfLsb));
      mag11_d[k] = RndW'(dt[k] >> Frac);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag11_q <= mag11_d;
      for (int k = 0; k < 3; k++) begin
        pos11_q[k] <= dots[k][DotW-1];
      end
      u11_q <= u10_q;
      r11_q <= r10_q;
      f11_q <= f10_q;
    end
  end

  lav_pkg::out_t out_d;
  lav_pkg::out_t out_q;

  always_comb begin
    out_d.right_x       = CoordW'($signed(r11_q[0]));
    out_d.right_y       = CoordW'($signed(r11_q[1]));
    out_d.right_z       = CoordW'($signed(r11_q[2]));
    out_d.right_shift   = lav_pkg::sat_shift(pos11_q[0], mag11_q[0]);
    out_d.true_up_x     = CoordW'($signed(u11_q[0]));
    out_d.true_up_y     = CoordW'($signed(u11_q[1]));
    out_d.true_up_z     = CoordW'($signed(u11_q[2]));
    out_d.true_up_shift = lav_pkg::sat_shift(pos11_q[1], mag11_q[1]);
    out_d.back_x        = CoordW'($signed(f11_q[0]));
    out_d.back_y        = CoordW'($signed(f11_q[1]));
    out_d.back_z        = CoordW'($signed(f11_q[2]));
    out_d.back_shift    = lav_pkg::sat_shift(pos11_q[2], mag11_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/core/lav_checker.sv
`timescale 1ns / 1ps
// port-level checks for the look-at view matrix and the bind that attaches them
// depends on lav_pkg and look_at_view_matrix

module lav_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input lav_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input lav_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled output payload changed");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(out_data_o.back_x) <= 32'sd65536
      && $signed(out_data_o.back_x) >= -32'sd65536
      && $signed(out_data_o.right_z) <= 32'sd65536
      && $signed(out_data_o.right_z) >= -32'sd65536)
    else $error("unit row component out of range");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);
